>>> rtl/wsfe_pkg.sv
// Shared types and constants for the WebSocket frame encoder.
// Used by wsfe_front, wsfe_queue, wsfe_back and websocket_frame_encoder.
// No dependencies.
package wsfe_pkg;

   // Item kinds on the request channel.
   localparam logic MODE_HEADER = 1'b0;
   localparam logic MODE_DATA   = 1'b1;

   // Length codes placed in header byte one for extended lengths.
   localparam logic [6:0] LEN_CODE_TWO   = 7'd126;
   localparam logic [6:0] LEN_CODE_EIGHT = 7'd127;

   // Queue between the front and back ends; depth must be a power of two.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Form of the extended length field.
   typedef enum logic [1:0] {
      EXT_NONE  = 2'b00,
      EXT_TWO   = 2'b01,
      EXT_EIGHT = 2'b10
   } ext_type;

   // One queued work unit: either a full header or one finished payload byte.
   typedef struct packed {
      logic        is_header;
      logic [7:0]  first_byte;   // header byte zero, or the masked payload byte
      logic        last;         // data: ends the frame; header: empty payload
      logic        masked;
      logic [6:0]  len_code;
      ext_type     ext;
      logic [31:0] mask_key;
      logic [62:0] length;
   } entry_type;

endpackage

>>> rtl/wsfe_front.sv
// Front end of the WebSocket frame encoder: accepts request transactions,
// classifies headers, tracks the open frame and masks payload bytes.
// Depends on wsfe_pkg.
module wsfe_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_mode,
   input  logic                 req_final_flag,
   input  logic [2:0]           req_reserved_bits,
   input  logic [3:0]           req_opcode,
   input  logic                 req_masked,
   input  logic [31:0]          req_mask_key,
   input  logic [62:0]          req_payload_length,
   input  logic [7:0]           req_data_byte,
   input  logic                 queue_full,
   output logic                 push,
   output wsfe_pkg::entry_type  push_entry
);

   logic        frame_open_ff, frame_open_in;
   logic        mask_enable_ff, mask_enable_in;
   logic [31:0] mask_ff, mask_in;
   logic [62:0] remaining_ff, remaining_in;
   logic [1:0]  phase_ff, phase_in;

   logic        accept;
   logic        is_hdr;
   logic        len_zero;
   logic [7:0]  key_byte;
   logic        data_last;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign is_hdr    = (req_mode == wsfe_pkg::MODE_HEADER);
   assign len_zero  = (req_payload_length == 63'd0);
   assign data_last = (remaining_ff == 63'd1);

   // Mask byte for the current payload position, most significant first.
   always_comb begin
      unique case (phase_ff)
         2'd0:    key_byte = mask_ff[31:24];
         2'd1:    key_byte = mask_ff[23:16];
         2'd2:    key_byte = mask_ff[15:8];
         default: key_byte = mask_ff[7:0];
      endcase
   end

   // Build the queue entry from the incoming transaction.
   always_comb begin
      push_entry           = '0;
      push_entry.is_header = is_hdr;
      push_entry.masked    = req_masked;
      push_entry.mask_key  = req_mask_key;
      push_entry.length    = req_payload_length;
      if (is_hdr) begin
         push_entry.first_byte = {req_final_flag, req_reserved_bits, req_opcode};
         push_entry.last       = len_zero;
         if (req_payload_length < 63'd126) begin
            push_entry.len_code = req_payload_length[6:0];
            push_entry.ext      = wsfe_pkg::EXT_NONE;
         end else if (req_payload_length[62:16] == 47'd0) begin
            push_entry.len_code = wsfe_pkg::LEN_CODE_TWO;
            push_entry.ext      = wsfe_pkg::EXT_TWO;
         end else begin
            push_entry.len_code = wsfe_pkg::LEN_CODE_EIGHT;
            push_entry.ext      = wsfe_pkg::EXT_EIGHT;
         end
      end else begin
         push_entry.first_byte = req_data_byte ^ (mask_enable_ff ? key_byte : 8'd0);
         push_entry.last       = data_last;
      end
   end

   // Data arriving with no open frame is consumed without a result.
   assign push = accept && (is_hdr || frame_open_ff);

   // Frame state update.
   always_comb begin
      frame_open_in  = frame_open_ff;
      mask_enable_in = mask_enable_ff;
      mask_in        = mask_ff;
      remaining_in   = remaining_ff;
      phase_in       = phase_ff;
      if (accept && is_hdr) begin
         frame_open_in  = !len_zero;
         mask_enable_in = req_masked;
         mask_in        = req_mask_key;
         remaining_in   = req_payload_length;
         phase_in       = 2'd0;
      end else if (accept && frame_open_ff) begin
         frame_open_in = !data_last;
         remaining_in  = remaining_ff - 63'd1;
         phase_in      = phase_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_open_ff  <= 1'b0;
         mask_enable_ff <= 1'b0;
         mask_ff        <= '0;
         remaining_ff   <= '0;
         phase_ff       <= '0;
      end else begin
         frame_open_ff  <= frame_open_in;
         mask_enable_ff <= mask_enable_in;
         mask_ff        <= mask_in;
         remaining_ff   <= remaining_in;
         phase_ff       <= phase_in;
      end
   end

`ifndef SYNTHESIS
   // An open frame always has payload bytes left to carry.
   a_open_has_bytes: assert property (@(posedge clock) disable iff (reset)
      frame_open_ff |-> (remaining_ff != 63'd0))
      else $error("frame open with no bytes remaining");

   // Nothing is pushed into a full queue.
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !queue_full)
      else $error("push into full queue");

   // A header with empty payload leaves no frame open.
   a_empty_closes: assert property (@(posedge clock) disable iff (reset)
      (accept && is_hdr && len_zero) |=> !frame_open_ff)
      else $error("empty frame left open");
`endif

endmodule

>>> rtl/wsfe_queue.sv
// Short register queue that decouples the front end from the serializer.
// Depends on wsfe_pkg.
module wsfe_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  wsfe_pkg::entry_type  push_entry,
   input  logic                 pop,
   output logic                 full,
   output logic                 head_valid,
   output wsfe_pkg::entry_type  head_entry
);

   wsfe_pkg::entry_type                 storage_ff [wsfe_pkg::QUEUE_DEPTH];
   logic [wsfe_pkg::QPTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [wsfe_pkg::QPTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [wsfe_pkg::QCNT_W-1:0]         count_ff, count_in;

   assign full       = (count_ff == wsfe_pkg::QCNT_W'(wsfe_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = storage_ff[rd_ptr_ff];

   // Pointer and occupancy bookkeeping.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + wsfe_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + wsfe_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + wsfe_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - wsfe_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage carries no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         storage_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> rtl/wsfe_back.sv
// Back end of the WebSocket frame encoder: expands queued headers into
// bytes, passes payload bytes through, and holds the response register.
// Depends on wsfe_pkg.
module wsfe_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  wsfe_pkg::entry_type  head_entry,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_frame_end
);

   logic [3:0]  step_ff, step_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  out_byte_ff;
   logic        frame_end_ff;

   logic [3:0]  ext_n;
   logic [3:0]  last_step;
   logic [63:0] len_word;
   logic [2:0]  len_idx;
   logic [1:0]  key_idx;
   logic [7:0]  hdr_byte;
   logic [7:0]  emit_byte;
   logic        emit_end;
   logic        done;
   logic        load;

   // Size of the extended length field.
   always_comb begin
      unique case (head_entry.ext)
         wsfe_pkg::EXT_TWO:   ext_n = 4'd2;
         wsfe_pkg::EXT_EIGHT: ext_n = 4'd8;
         default:             ext_n = 4'd0;
      endcase
   end

   assign last_step = 4'd1 + ext_n + (head_entry.masked ? 4'd4 : 4'd0);
   assign len_word  = {1'b0, head_entry.length};
   assign len_idx   = 3'(ext_n + 4'd1 - step_ff);
   assign key_idx   = 2'(step_ff - 4'd2 - ext_n);

   // Header byte at the current step: byte zero, byte one, length, key.
   always_comb begin
      if (step_ff == 4'd0) begin
         hdr_byte = head_entry.first_byte;
      end else if (step_ff == 4'd1) begin
         hdr_byte = {head_entry.masked, head_entry.len_code};
      end else if (step_ff < 4'd2 + ext_n) begin
         hdr_byte = len_word[{len_idx, 3'b000} +: 8];
      end else begin
         hdr_byte = head_entry.mask_key[{~key_idx, 3'b000} +: 8];
      end
   end

   assign done      = !head_entry.is_header || (step_ff == last_step);
   assign emit_byte = head_entry.is_header ? hdr_byte : head_entry.first_byte;
   assign emit_end  = head_entry.is_header ? (head_entry.last && done) : head_entry.last;

   // Output register takes a new byte whenever it is empty or draining.
   assign load = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign pop  = load && done;

   always_comb begin
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load) begin
         step_in      = done ? 4'd0 : step_ff + 4'd1;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_byte_ff  <= emit_byte;
         frame_end_ff <= emit_end;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = out_byte_ff;
   assign rsp_frame_end = frame_end_ff;

`ifndef SYNTHESIS
   // The step counter never runs past the header length.
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (head_valid && head_entry.is_header) |-> (step_ff <= last_step))
      else $error("header step out of range");

   // A header part way through expansion stays at the head of the queue.
   a_mid_header: assert property (@(posedge clock) disable iff (reset)
      (step_ff != 4'd0) |-> (head_valid && head_entry.is_header))
      else $error("step set without a header at the head");

   // Without a load the expansion position holds.
   a_step_hold: assert property (@(posedge clock) disable iff (reset)
      (head_valid && !load) |=> $stable(step_ff))
      else $error("step moved while stalled");
`endif

endmodule

>>> rtl/websocket_frame_encoder.sv
// WebSocket frame encoder (RFC 6455 transmit framing), top level.
// Channels: req_* carries header transactions (req_mode 0) and payload
// byte transactions (req_mode 1); rsp_* delivers the frame one byte per
// transaction, with rsp_frame_end set on the last byte of each frame.
// A header produces 2 to 14 bytes: byte zero, byte one, a 2 or 8 byte
// big-endian extended length when needed, then the mask key when masked.
// Each payload byte produces one byte, XORed with the mask when masked.
// Payload bytes with no open frame are consumed and produce nothing.
// With nothing queued ahead, an accepted transaction is first written into
// the queue, and its first byte then passes through the output register
// onto rsp. Payload bytes sustain one per cycle while rsp_stall is low.
// A header holds the serializer until all of its bytes are out; a
// four-entry queue between the front and the serializer absorbs requests meanwhile.
// req_stall is high while that queue is full.
// Reset (synchronous) empties the queue and the output register and
// closes any open frame. While rsp_stall is high the output byte holds,
// the queue fills, and then req_stall rises.
// Depends on wsfe_pkg, wsfe_front, wsfe_queue and wsfe_back.
module websocket_frame_encoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic        req_final_flag,
   input  logic [2:0]  req_reserved_bits,
   input  logic [3:0]  req_opcode,
   input  logic        req_masked,
   input  logic [31:0] req_mask_key,
   input  logic [62:0] req_payload_length,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_frame_end
);

   logic                queue_full;
   logic                push;
   wsfe_pkg::entry_type push_entry;
   logic                pop;
   logic                head_valid;
   wsfe_pkg::entry_type head_entry;

   // Front end: accept, classify and mask.
   wsfe_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_final_flag     (req_final_flag),
      .req_reserved_bits  (req_reserved_bits),
      .req_opcode         (req_opcode),
      .req_masked         (req_masked),
      .req_mask_key       (req_mask_key),
      .req_payload_length (req_payload_length),
      .req_data_byte      (req_data_byte),
      .queue_full         (queue_full),
      .push               (push),
      .push_entry         (push_entry)
   );

   // Decoupling queue.
   wsfe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   // Serializer and response register.
   wsfe_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_entry    (head_entry),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

>>> tb/websocket_frame_encoder_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for websocket_frame_encoder: header and payload transactions
// go in, serialized frame bytes are predicted in the bench and compared as they come out.
// Depends on wsfe_pkg and the websocket_frame_encoder RTL.
module websocket_frame_encoder_test;

   // One request transaction, plus a flag that makes the driver wait for an empty pipe.
   typedef struct packed {
      logic        mode;
      logic        final_flag;
      logic [2:0]  reserved_bits;
      logic [3:0]  opcode;
      logic        masked;
      logic [31:0] mask_key;
      logic [62:0] payload_length;
      logic [7:0]  data_byte;
      logic        drain_first;
   } ws_request_type;

   // One byte of the serialized frame.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       frame_end;
   } ws_wire_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_mode = wsfe_pkg::MODE_HEADER;
   logic        req_final_flag = 1'b0;
   logic [2:0]  req_reserved_bits = 3'd0;
   logic [3:0]  req_opcode = 4'd0;
   logic        req_masked = 1'b0;
   logic [31:0] req_mask_key = 32'd0;
   logic [62:0] req_payload_length = 63'd0;
   logic [7:0]  req_data_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_frame_end;

   ws_request_type   pending_requests[$];
   ws_wire_byte_type expected_bytes[$];
   ws_request_type   active_req;
   ws_request_type   next_req;
   ws_wire_byte_type want;
   int          errors = 0;
   int          item_total = 0;
   int          gap_left = 0;
   int          burst_left = 1;
   int          stall_style = 0;
   int          stall_left = 0;

   // Mirror of the encoder's frame state.
   logic        tx_open = 1'b0;
   logic        tx_mask_on = 1'b0;
   logic [31:0] tx_mask_key = 32'd0;
   logic [62:0] tx_remaining = 63'd0;
   logic [1:0]  tx_phase = 2'd0;

   websocket_frame_encoder dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_final_flag     (req_final_flag),
      .req_reserved_bits  (req_reserved_bits),
      .req_opcode         (req_opcode),
      .req_masked         (req_masked),
      .req_mask_key       (req_mask_key),
      .req_payload_length (req_payload_length),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_frame_end      (rsp_frame_end)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Work out the frame bytes that one accepted request must produce.
   task automatic predict_frame_bytes(input ws_request_type r);
      logic [7:0]  hdr[14];
      logic [6:0]  len_code;
      logic [62:0] shifted;
      logic [31:0] key_shift;
      logic [7:0]  b;
      int          ext_bytes;
      int          n;
      int          i;
      ws_wire_byte_type w;
      if (r.mode == wsfe_pkg::MODE_HEADER) begin
         if (r.payload_length < 63'd126) begin
            len_code = r.payload_length[6:0];
            ext_bytes = 0;
         end else if (r.payload_length <= 63'd65535) begin
            len_code = wsfe_pkg::LEN_CODE_TWO;
            ext_bytes = 2;
         end else begin
            len_code = wsfe_pkg::LEN_CODE_EIGHT;
            ext_bytes = 8;
         end
         hdr[0] = {r.final_flag, r.reserved_bits, r.opcode};
         hdr[1] = {r.masked, len_code};
         n = 2;
         // Extended length goes out most significant byte first.
         for (i = ext_bytes - 1; i >= 0; i--) begin
            shifted = r.payload_length >> (8 * i);
            hdr[n] = shifted[7:0];
            n++;
         end
         if (r.masked) begin
            for (i = 3; i >= 0; i--) begin
               key_shift = r.mask_key >> (8 * i);
               hdr[n] = key_shift[7:0];
               n++;
            end
         end
         // An empty payload closes the frame on its last header byte.
         for (i = 0; i < n; i++) begin
            w.out_byte = hdr[i];
            w.frame_end = (r.payload_length == 63'd0) && (i == n - 1);
            expected_bytes.push_back(w);
         end
         tx_mask_on = r.masked;
         tx_mask_key = r.mask_key;
         tx_phase = 2'd0;
         tx_remaining = r.payload_length;
         tx_open = (r.payload_length != 63'd0);
      end else if (tx_open) begin
         key_shift = tx_mask_key >> (8 * (3 - tx_phase));
         b = tx_mask_on ? (r.data_byte ^ key_shift[7:0]) : r.data_byte;
         tx_phase = tx_phase + 2'd1;
         tx_remaining = tx_remaining - 63'd1;
         if (tx_remaining == 63'd0)
            tx_open = 1'b0;
         w.out_byte = b;
         w.frame_end = !tx_open;
         expected_bytes.push_back(w);
      end
   endtask

   task automatic add_header(input logic fin, input logic [2:0] rsv, input logic [3:0] op,
                             input logic msk, input logic [31:0] key,
                             input logic [62:0] len, input logic drain);
      ws_request_type r;
      r.mode = wsfe_pkg::MODE_HEADER;
      r.final_flag = fin;
      r.reserved_bits = rsv;
      r.opcode = op;
      r.masked = msk;
      r.mask_key = key;
      r.payload_length = len;
      r.data_byte = 8'($urandom);
      r.drain_first = drain;
      pending_requests.push_back(r);
      item_total++;
   endtask

   // Payload byte; header fields carry junk since the block must ignore them.
   task automatic add_data(input logic [7:0] b, input bit counted);
      ws_request_type r;
      r.mode = wsfe_pkg::MODE_DATA;
      r.final_flag = 1'($urandom);
      r.reserved_bits = 3'($urandom);
      r.opcode = 4'($urandom);
      r.masked = 1'($urandom);
      r.mask_key = $urandom;
      r.payload_length = 63'({$urandom, $urandom});
      r.data_byte = b;
      r.drain_first = 1'b0;
      pending_requests.push_back(r);
      if (counted)
         item_total++;
   endtask

   task automatic add_random_header(input logic [62:0] len);
      add_header(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), $urandom, len,
                 $urandom_range(0, 40) == 0);
   endtask

   // Driver: sends pending transactions in bursts with random gaps and predicts on acceptance.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            predict_frame_bytes(active_req);
         if (req_valid && req_stall) begin
            // Stalled: hold the payload as it is.
         end else if (gap_left != 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_requests.size() != 0) begin
            next_req = pending_requests[0];
            if (!next_req.drain_first || expected_bytes.size() == 0) begin
               active_req = pending_requests.pop_front();
               req_mode <= active_req.mode;
               req_final_flag <= active_req.final_flag;
               req_reserved_bits <= active_req.reserved_bits;
               req_opcode <= active_req.opcode;
               req_masked <= active_req.masked;
               req_mask_key <= active_req.mask_key;
               req_payload_length <= active_req.payload_length;
               req_data_byte <= active_req.data_byte;
               req_valid <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 24);
                  gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: checks every accepted output byte and stalls on a shifting pattern.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_bytes.size() == 0) begin
               errors++;
               $display("%0t: unexpected transaction, expected none, actual byte %02h end %0b",
                        $time, rsp_out_byte, rsp_frame_end);
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_out_byte !== want.out_byte) begin
                  errors++;
                  $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                           $time, want.out_byte, rsp_out_byte);
               end
               if (rsp_frame_end !== want.frame_end) begin
                  errors++;
                  $display("%0t: frame_end mismatch, expected %0b, actual %0b",
                           $time, want.frame_end, rsp_frame_end);
               end
            end
         end
         // Pick a new stall style now and then: none, light, alternating or heavy.
         if (stall_left == 0) begin
            stall_style <= $urandom_range(0, 3);
            stall_left <= $urandom_range(8, 60);
         end else begin
            stall_left <= stall_left - 1;
         end
         case (stall_style)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 2) == 0);
            2: rsp_stall <= ~rsp_stall;
            default: rsp_stall <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   // Stimulus, reset and end of test.
   initial begin
      int          kind;
      int          count;
      int          i;
      logic [62:0] len;

      // Directed part: field extremes, empty payloads, stray data, abandoned frames.
      add_header(1'b1, 3'd7, 4'd15, 1'b1, 32'hFFFF_FFFF, 63'd0, 1'b0);
      add_header(1'b0, 3'd0, 4'd0, 1'b0, 32'h0000_0000, 63'd0, 1'b0);
      add_data(8'hFF, 1'b1);
      add_header(1'b0, 3'd5, 4'd1, 1'b1, 32'h0102_0304, 63'd125, 1'b0);
      add_data(8'h00, 1'b1);
      add_data(8'hFF, 1'b1);
      add_data(8'h5A, 1'b1);
      add_header(1'b1, 3'd2, 4'd2, 1'b0, 32'h1234_5678, 63'd126, 1'b0);
      add_data(8'h11, 1'b1);
      add_header(1'b0, 3'd0, 4'd10, 1'b1, 32'hA5A5_A5A5, 63'd65535, 1'b1);
      add_header(1'b1, 3'd1, 4'd9, 1'b1, 32'h8000_0001, 63'd65536, 1'b0);
      add_header(1'b1, 3'd7, 4'd0, 1'b1, 32'hDEAD_BEEF, 63'h7FFF_FFFF_FFFF_FFFF, 1'b0);
      add_data(8'hFF, 1'b1);
      add_data(8'h00, 1'b1);
      add_header(1'b1, 3'd0, 4'd8, 1'b1, 32'h0F1E_2D3C, 63'd4, 1'b0);
      add_data(8'hAA, 1'b1);
      add_data(8'h55, 1'b1);
      add_data(8'hFF, 1'b1);
      add_data(8'h00, 1'b1);
      add_data(8'h00, 1'b1);
      add_header(1'b0, 3'd4, 4'd9, 1'b0, 32'hFFFF_FFFF, 63'd1, 1'b0);
      add_data(8'hC3, 1'b1);

      // Random part: mostly complete frames, some abandoned ones, a little stray data.
      while (item_total < 310) begin
         kind = $urandom_range(0, 9);
         if (kind < 7) begin
            len = ($urandom_range(0, 4) == 0) ? 63'($urandom_range(10, 40))
                                               : 63'($urandom_range(0, 9));
            add_random_header(len);
            for (i = 0; i < len; i++)
               add_data(8'($urandom), 1'b1);
         end else if (kind < 9) begin
            case ($urandom_range(0, 4))
               0: len = 63'($urandom_range(0, 125));
               1: len = 63'($urandom_range(126, 65535));
               2: len = ($urandom_range(0, 1) == 0) ? 63'd125 : 63'd65536;
               default: begin
                  len = 63'({$urandom, $urandom});
                  if (len < 63'd65536)
                     len = len + 63'd65536;
               end
            endcase
            add_random_header(len);
            count = $urandom_range(0, 5);
            for (i = 0; i < count; i++)
               add_data(8'($urandom), 1'b1);
         end else begin
            count = $urandom_range(1, 3);
            for (i = 0; i < count; i++)
               add_data(8'($urandom), 1'b1);
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || req_valid)
         @(posedge clock);
      while (expected_bytes.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0)
         $display("PASS websocket_frame_encoder");
      else
         $display("FAIL websocket_frame_encoder");
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #3_000_000;
      $display("FAIL websocket_frame_encoder");
      $finish;
   end

endmodule
